FILE: rtl/dhtbc_pkg.sv
`default_nettype none

package dhtbc_pkg;

    // Widths fixed by the register map
    localparam int REG_BITS        = 20;
    localparam int CFG_IDX_BITS    = 8;
    localparam int COUNT_BITS_DEF  = 20;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WEB      = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PORTAL   = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RESET    = 8'd3;

    // Register reset values
    localparam logic [REG_BITS-1:0] DEBOUNCE_RST = 20'd50;
    localparam logic [REG_BITS-1:0] WEB_RST      = 20'd5000;
    localparam logic [REG_BITS-1:0] PORTAL_RST   = 20'd15000;
    localparam logic [REG_BITS-1:0] RESET_RST    = 20'd30000;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_SHORT     = 3'd1,
        EV_WEB       = 3'd2,
        EV_PORTAL    = 3'd3,
        EV_ARMED     = 3'd4,
        EV_CONFIRMED = 3'd5
    } t_event;

    typedef struct packed {
        logic raw_level;
        logic take_event;
    } t_in_req;

    typedef struct packed {
        t_event event_code;
        logic   stable_pressed;
    } t_out_rsp;

endpackage

`default_nettype wire

FILE: rtl/debounced_hold_time_button_classifier.sv
`default_nettype none
// An accepted request's result is registered. Throughput: one request per cycle
// while no result is stalled; the whole tick update is a single pass of compares
// and saturating increments ahead of the state and result registers.
// Reset (synchronous, active low) restores the register defaults, releases the
// debounced level, clears counters, hold flags and the pending event.

module debounced_hold_time_button_classifier
    import dhtbc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration write port
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [REG_BITS-1:0]     i_cfg_data,
    // tick request channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire t_in_req                 i_in_req,
    // result channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output t_out_rsp                     o_out_rsp
);

    // Compare width covers both the counters and the threshold registers
    localparam int CMP_W = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;

    // Threshold registers
    logic [REG_BITS-1:0]   r_debounce_ticks;
    logic [REG_BITS-1:0]   r_web_hold_ticks;
    logic [REG_BITS-1:0]   r_portal_hold_ticks;
    logic [REG_BITS-1:0]   r_reset_hold_ticks;

    // Button state
    logic                  r_last_raw,     n_last_raw;
    logic                  r_stable_level, n_stable_level;
    logic [COUNT_BITS-1:0] r_since_change, n_since_change;
    logic [COUNT_BITS-1:0] r_held_ticks,   n_held_ticks;
    logic                  r_web_sent,     n_web_sent;
    logic                  r_portal_sent,  n_portal_sent;
    logic                  r_reset_armed,  n_reset_armed;
    t_event                r_pending,      n_pending;

    // Result register
    logic                  r_out_valid;
    t_out_rsp              r_out_rsp,      n_out_rsp;

    logic                  in_accept;

    // The output register frees up in the same cycle its result is taken
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // One tick of the debounce and hold classifier
    always_comb begin
        logic raw;
        raw            = i_in_req.raw_level;
        n_last_raw     = r_last_raw;
        n_stable_level = r_stable_level;
        n_held_ticks   = r_held_ticks;
        n_web_sent     = r_web_sent;
        n_portal_sent  = r_portal_sent;
        n_reset_armed  = r_reset_armed;
        n_pending      = r_pending;

        // held count runs while the previous debounced level is pressed
        if (!r_stable_level && (r_held_ticks != '1)) begin
            n_held_ticks = r_held_ticks + 1'b1;
        end

        // any raw edge restarts the debounce count
        if (raw != r_last_raw) begin
            n_last_raw     = raw;
            n_since_change = '0;
        end else if (r_since_change != '1) begin
            n_since_change = r_since_change + 1'b1;
        end else begin
            n_since_change = r_since_change;
        end

        if (CMP_W'(n_since_change) >= CMP_W'(r_debounce_ticks)) begin
            if (raw != r_stable_level) begin
                n_stable_level = raw;
                if (!raw) begin
                    // fresh press
                    n_held_ticks  = '0;
                    n_web_sent    = 1'b0;
                    n_portal_sent = 1'b0;
                    n_reset_armed = 1'b0;
                end else if (r_reset_armed) begin
                    n_pending     = EV_CONFIRMED;
                    n_reset_armed = 1'b0;
                end else if (!r_web_sent && !r_portal_sent) begin
                    n_pending = EV_SHORT;
                end
            end

            // hold thresholds, later ones win the pending slot
            if (!n_stable_level) begin
                if (!n_web_sent &&
                    (CMP_W'(n_held_ticks) >= CMP_W'(r_web_hold_ticks))) begin
                    n_web_sent = 1'b1;
                    n_pending  = EV_WEB;
                end
                if (!n_portal_sent &&
                    (CMP_W'(n_held_ticks) >= CMP_W'(r_portal_hold_ticks))) begin
                    n_portal_sent = 1'b1;
                    n_pending     = EV_PORTAL;
                end
                if (!n_reset_armed &&
                    (CMP_W'(n_held_ticks) >= CMP_W'(r_reset_hold_ticks))) begin
                    n_reset_armed = 1'b1;
                    n_pending     = EV_ARMED;
                end
            end
        end

        // report and clear the pending event on request
        n_out_rsp.stable_pressed = !n_stable_level;
        if (i_in_req.take_event) begin
            n_out_rsp.event_code = n_pending;
            n_pending            = EV_NONE;
        end else begin
            n_out_rsp.event_code = EV_NONE;
        end
    end

    // Configuration, state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks    <= DEBOUNCE_RST;
            r_web_hold_ticks    <= WEB_RST;
            r_portal_hold_ticks <= PORTAL_RST;
            r_reset_hold_ticks  <= RESET_RST;
            r_last_raw          <= 1'b1;
            r_stable_level      <= 1'b1;
            r_since_change      <= '0;
            r_held_ticks        <= '0;
            r_web_sent          <= 1'b0;
            r_portal_sent       <= 1'b0;
            r_reset_armed       <= 1'b0;
            r_pending           <= EV_NONE;
            r_out_valid         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_DEBOUNCE: r_debounce_ticks    <= i_cfg_data;
                    REG_WEB:      r_web_hold_ticks    <= i_cfg_data;
                    REG_PORTAL:   r_portal_hold_ticks <= i_cfg_data;
                    REG_RESET:    r_reset_hold_ticks  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_last_raw     <= n_last_raw;
                r_stable_level <= n_stable_level;
                r_since_change <= n_since_change;
                r_held_ticks   <= n_held_ticks;
                r_web_sent     <= n_web_sent;
                r_portal_sent  <= n_portal_sent;
                r_reset_armed  <= n_reset_armed;
                r_pending      <= n_pending;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_rsp <= n_out_rsp;
        end
    end

    // Assertions
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request accepted while result stalled");

    a_result_tracks_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_out_rsp.stable_pressed == !r_stable_level))
        else $error("reported level differs from debounced state");

    a_raw_edge_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_req.raw_level != r_last_raw)) |=> (r_since_change == '0))
        else $error("raw change did not restart debounce count");

    a_released_held_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stable_level && $past(r_stable_level) && $past(i_rst_n)) |-> $stable(r_held_ticks))
        else $error("held count moved while released");

    a_untaken_reports_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_in_req.take_event) |=> (r_out_rsp.event_code == EV_NONE))
        else $error("event reported without take request");

endmodule

`default_nettype wire
